/* src/assert_macros.svh */
// Assertion macros shared by the hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/fsh_pkg.sv */
// Package: constants, ALU op codes and shared types of the feature string hasher.
`timescale 1ns / 1ps

package fsh_pkg;

	localparam logic [31:0] MH_C1       = 32'hcc9e2d51;
	localparam logic [31:0] MH_C2       = 32'h1b873593;
	localparam logic [31:0] MH_C3       = 32'h85ebca6b;
	localparam logic [31:0] MH_C4       = 32'hc2b2ae35;
	localparam logic [31:0] MH_MIX_MUL  = 32'd5;
	localparam logic [31:0] MH_MIX_ADD  = 32'he6546b64;
	localparam logic [31:0] CHAIN_LEN   = 32'd8;
	localparam logic [7:0]  COLON_CHAR  = 8'h3a;
	localparam logic [3:0]  ICPT_LEN    = 4'd11;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VALUE_SEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIGN_SEED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE  = 2'd2;

	localparam logic [1:0] MODE_VALUE = 2'd0;
	localparam logic [1:0] MODE_SIGN  = 2'd1;
	localparam logic [1:0] MODE_INTER = 2'd2;

	typedef enum logic [2:0] {
		OP_SCR1 = 3'd0,
		OP_MIX2 = 3'd1,
		OP_XOR2 = 3'd2,
		OP_MIX3 = 3'd3,
		OP_FM1  = 3'd4,
		OP_FM2  = 3'd5,
		OP_FM3  = 3'd6
	} alu_op_t;

	typedef struct packed {
		alu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	// "(Intercept)"
	function automatic logic [7:0] icpt_char(input logic [3:0] pos);
		logic [7:0] c;
		case (pos)
			4'd0:    c = 8'h28;
			4'd1:    c = 8'h49;
			4'd2:    c = 8'h6e;
			4'd3:    c = 8'h74;
			4'd4:    c = 8'h65;
			4'd5:    c = 8'h72;
			4'd6:    c = 8'h63;
			4'd7:    c = 8'h65;
			4'd8:    c = 8'h70;
			4'd9:    c = 8'h74;
			4'd10:   c = 8'h29;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* src/feature_string_hasher_core.sv */
// Top level: byte-stream MurmurHash3 x86_32 feature hasher with config registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Bytes of a feature string enter one per request; the request flagged string_end closes
// the string and yields one signed 32-bit hash_result. All multiplies go through one shared
// 32x32 multiplier under a sequencer: a byte that completes a 4-byte block runs the block
// mix steps, and string end runs finalization (a POST step more in interaction mode) and
// then loads the result. In interaction mode each ':' and the string end finalize a token,
// and chaining a token into the running value adds a chain mix and a further finalization.
// The input stalls while the sequencer is busy; a finished result waits in an output
// register.
module feature_string_hasher_core import fsh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  logic                 byte_valid,
	output logic                 byte_stall,
	input  logic [7:0]           text_byte,
	input  logic                 string_end,
	output logic                 hash_valid,
	input  logic                 hash_stall,
	output logic signed [31:0]   hash_result
);

	typedef enum logic [16:0] {
		S_IDLE   = 17'h00001,
		S_TM_K   = 17'h00002,
		S_TM_X   = 17'h00004,
		S_TM_A   = 17'h00008,
		S_FIN_S  = 17'h00010,
		S_FIN_X  = 17'h00020,
		S_FIN_M1 = 17'h00040,
		S_FIN_M2 = 17'h00080,
		S_FIN_M3 = 17'h00100,
		S_CH_S   = 17'h00200,
		S_CH_X1  = 17'h00400,
		S_CH_A1  = 17'h00800,
		S_CH_K2  = 17'h01000,
		S_CH_X2  = 17'h02000,
		S_CH_A2  = 17'h04000,
		S_POST   = 17'h08000,
		S_OUT    = 17'h10000
	} state_t;

	state_t      state_q;
	logic [31:0] value_seed_q;
	logic [31:0] sign_seed_q;
	logic [1:0]  hash_mode_q;
	logic [31:0] h_q;
	logic [31:0] pw_q;
	logic [31:0] len_q;
	logic [31:0] chain_q;
	logic        have_q;
	logic        colon_q;
	logic        last_q;
	logic        chain_fin_q;
	logic        hash_valid_q;
	logic [31:0] acc_q;
	logic [31:0] k_q;
	logic [31:0] tok_q;
	logic [31:0] res_q;

	alu_req_t    alu_req;
	logic [31:0] alu_res;
	logic        byte_take;
	logic        is_colon;
	logic        out_free;
	logic        icpt_hit;
	logic [31:0] tok_seed;
	logic [31:0] pw_next;
	logic [31:0] fin_word;

	assign cfg_ready   = 1'b1;
	assign byte_stall  = (state_q != S_IDLE);
	assign byte_take   = byte_valid && !byte_stall;
	assign is_colon    = (hash_mode_q == MODE_INTER) && (text_byte == COLON_CHAR);
	assign out_free    = !hash_valid_q || !hash_stall;
	assign hash_valid  = hash_valid_q;
	assign hash_result = $signed(res_q);
	assign tok_seed    = (hash_mode_q == MODE_SIGN) ? sign_seed_q : value_seed_q;
	assign pw_next     = pw_q | ({24'd0, text_byte} << {len_q[1:0], 3'b000});

	always_comb begin
		if (icpt_hit)
			fin_word = '0;
		else if (hash_mode_q == MODE_SIGN)
			fin_word = alu_res[31] ? '1 : 32'd1;
		else
			fin_word = alu_res;
	end

	always_comb begin
		alu_req.op = OP_FM3;
		alu_req.a  = acc_q;
		alu_req.b  = acc_q;
		unique case (state_q)
			S_TM_K, S_FIN_S: begin
				alu_req.op = OP_SCR1;
				alu_req.a  = pw_q;
			end
			S_TM_X: begin
				alu_req.op = OP_MIX2;
				alu_req.a  = k_q;
				alu_req.b  = h_q;
			end
			S_TM_A: begin
				alu_req.op = OP_MIX3;
				alu_req.a  = h_q;
			end
			S_FIN_X: begin
				alu_req.op = OP_XOR2;
				alu_req.a  = k_q;
			end
			S_FIN_M1: begin
				alu_req.op = OP_FM1;
				alu_req.b  = chain_fin_q ? CHAIN_LEN : len_q;
			end
			S_FIN_M2: alu_req.op = OP_FM2;
			S_CH_S: begin
				alu_req.op = OP_SCR1;
				alu_req.a  = chain_q;
			end
			S_CH_K2: begin
				alu_req.op = OP_SCR1;
				alu_req.a  = tok_q;
			end
			S_CH_X1, S_CH_X2: begin
				alu_req.op = OP_MIX2;
				alu_req.a  = k_q;
			end
			S_CH_A1, S_CH_A2: alu_req.op = OP_MIX3;
			default: alu_req.op = OP_FM3;
		endcase
	end

	fsh_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	fsh_icpt u_icpt (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (byte_take),
		.data   (text_byte),
		.clr    ((state_q == S_OUT) && out_free),
		.hit    (icpt_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_seed_q <= '0;
			sign_seed_q  <= '0;
			hash_mode_q  <= MODE_VALUE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VALUE_SEED: value_seed_q <= cfg_data;
				REG_SIGN_SEED:  sign_seed_q  <= cfg_data;
				REG_HASH_MODE:  hash_mode_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && out_free) begin
			hash_valid_q <= 1'b1;
		end else if (!hash_stall) begin
			hash_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			h_q         <= '0;
			pw_q        <= '0;
			len_q       <= '0;
			chain_q     <= '0;
			have_q      <= 1'b0;
			colon_q     <= 1'b0;
			last_q      <= 1'b0;
			chain_fin_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (byte_take) begin
					last_q  <= string_end;
					colon_q <= is_colon;
					if (is_colon) begin
						state_q <= S_FIN_S;
					end else begin
						if (len_q == '0)
							h_q <= tok_seed;
						pw_q  <= pw_next;
						len_q <= len_q + 32'd1;
						if (len_q[1:0] == 2'd3)
							state_q <= S_TM_K;
						else if (string_end)
							state_q <= S_FIN_S;
					end
				end
				S_TM_K: state_q <= S_TM_X;
				S_TM_X: begin
					h_q     <= alu_res;
					state_q <= S_TM_A;
				end
				S_TM_A: begin
					h_q     <= alu_res;
					pw_q    <= '0;
					state_q <= last_q ? S_FIN_S : S_IDLE;
				end
				S_FIN_S: state_q <= (len_q[1:0] != 2'd0) ? S_FIN_X : S_FIN_M1;
				S_FIN_X: state_q <= S_FIN_M1;
				S_FIN_M1: state_q <= S_FIN_M2;
				S_FIN_M2: state_q <= S_FIN_M3;
				S_FIN_M3: begin
					if (chain_fin_q) begin
						chain_q     <= alu_res;
						chain_fin_q <= 1'b0;
						state_q     <= S_POST;
					end else if (hash_mode_q == MODE_INTER) begin
						if (!have_q) begin
							chain_q <= alu_res;
							have_q  <= 1'b1;
							state_q <= S_POST;
						end else begin
							state_q <= S_CH_S;
						end
					end else begin
						state_q <= S_OUT;
					end
				end
				S_CH_S:  state_q <= S_CH_X1;
				S_CH_X1: state_q <= S_CH_A1;
				S_CH_A1: state_q <= S_CH_K2;
				S_CH_K2: state_q <= S_CH_X2;
				S_CH_X2: state_q <= S_CH_A2;
				S_CH_A2: begin
					chain_fin_q <= 1'b1;
					state_q     <= S_FIN_M1;
				end
				S_POST: begin
					if (colon_q) begin
						h_q     <= '0;
						pw_q    <= '0;
						len_q   <= '0;
						colon_q <= 1'b0;
						state_q <= last_q ? S_FIN_S : S_IDLE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: if (out_free) begin
					h_q     <= '0;
					pw_q    <= '0;
					len_q   <= '0;
					chain_q <= '0;
					have_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath temporaries, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_TM_K: k_q <= alu_res;
			S_FIN_S: begin
				acc_q <= (len_q == '0) ? tok_seed : h_q;
				k_q   <= alu_res;
			end
			S_FIN_X, S_FIN_M1, S_FIN_M2: acc_q <= alu_res;
			S_FIN_M3: begin
				if (!chain_fin_q && (hash_mode_q == MODE_INTER))
					tok_q <= alu_res;
				else if (!chain_fin_q)
					acc_q <= fin_word;
			end
			S_CH_S: begin
				acc_q <= value_seed_q;
				k_q   <= alu_res;
			end
			S_CH_K2: k_q <= alu_res;
			S_CH_X1, S_CH_A1, S_CH_X2, S_CH_A2: acc_q <= alu_res;
			S_POST: if (!colon_q) acc_q <= chain_q;
			S_OUT: if (out_free) res_q <= acc_q;
			default: ;
		endcase
	end

	`ASSERT_IMPL(a_valid_from_out, $rose(hash_valid_q), $past(state_q == S_OUT), "result without sequencer output step")
	`ASSERT_IMPL(a_chain_needs_first, chain_fin_q, have_q, "chain finalization without first token")
	`ASSERT_IMPL(a_no_colon_at_out, state_q == S_OUT, !colon_q, "result issued inside a token split")
	`ASSERT_IMPL(a_block_aligned, state_q == S_TM_A, len_q[1:0] == 2'd0, "block mix on partial word")

endmodule

/* src/fsh_alu.sv */
// Shared MurmurHash3 step unit built around a single 32x32 multiplier.
`timescale 1ns / 1ps

module fsh_alu import fsh_pkg::*; (
	input  alu_req_t    req,
	output logic [31:0] res
);

	logic [31:0] pre;
	logic [31:0] mk;
	logic [31:0] prod;
	logic [31:0] xa;
	logic [31:0] y;

	always_comb begin
		xa  = req.a ^ req.b;
		pre = req.a;
		mk  = MH_C1;
		unique case (req.op)
			OP_SCR1: mk = MH_C1;
			OP_MIX2, OP_XOR2: mk = MH_C2;
			OP_MIX3: mk = MH_MIX_MUL;
			OP_FM1: begin
				pre = xa ^ (xa >> 16);
				mk  = MH_C3;
			end
			OP_FM2: begin
				pre = req.a ^ (req.a >> 13);
				mk  = MH_C4;
			end
			default: mk = MH_C1;
		endcase
	end

	assign prod = pre * mk;
	assign y    = req.b ^ prod;

	always_comb begin
		unique case (req.op)
			OP_SCR1: res = {prod[16:0], prod[31:17]};
			OP_MIX2: res = {y[18:0], y[31:19]};
			OP_XOR2: res = y;
			OP_MIX3: res = prod + MH_MIX_ADD;
			OP_FM1:  res = prod;
			OP_FM2:  res = prod;
			OP_FM3:  res = req.a ^ (req.a >> 16);
			default: res = prod;
		endcase
	end

endmodule

/* src/fsh_icpt.sv */
// Running match of the string against the "(Intercept)" literal.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fsh_icpt import fsh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data,
	input  logic       clr,
	output logic       hit
);

	logic [3:0] pos_q;
	logic       alive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			alive_q <= 1'b1;
		end else if (clr) begin
			pos_q   <= '0;
			alive_q <= 1'b1;
		end else if (take) begin
			if (alive_q && (pos_q < ICPT_LEN) && (data == icpt_char(pos_q)))
				pos_q <= pos_q + 4'd1;
			else
				alive_q <= 1'b0;
		end
	end

	assign hit = alive_q && (pos_q == ICPT_LEN);

	`ASSERT_ALWAYS(a_pos_range, pos_q <= ICPT_LEN, "intercept position out of range")
	`ASSERT_NEXT(a_dead_stays, !alive_q && !clr, !alive_q, "intercept match revived")
	`ASSERT_NEXT(a_clr_restart, clr, (pos_q == 4'd0) && alive_q, "intercept clear failed")

endmodule
